// File: rtl/lrs_pkg.sv
package lrs_pkg;

   localparam int NUM_FEATURES = 4;
   localparam int SIG_DEPTH    = 1024;
   localparam int IDX_W        = $clog2(SIG_DEPTH);
   localparam int CNT_W        = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   // dot product: 48-bit terms plus growth for the running sum
   localparam int SUM_W        = 49 + $clog2(NUM_FEATURES);
   localparam int SAT_W        = 28;
   localparam int MUL_A_W      = 34;
   localparam int MUL_B_W      = 18;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;

   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   typedef logic [15:0] sig_table_type [SIG_DEPTH];

   // shift-subtract division, only ever evaluated on constants
   function automatic longint unsigned udiv(input longint unsigned n,
                                            input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid at the bin centre, exp(-|x|) from a short series squared eight times
   function automatic logic [15:0] sig_entry(input int k);
      longint          num;
      longint          x;
      longint unsigned a;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned t3;
      longint unsigned t4;
      longint unsigned e;
      longint unsigned den;
      longint unsigned s;
      num = longint'(2 * k + 1) * (longint'(8) << 30);
      x   = num / SIG_DEPTH - (longint'(8) << 30);
      a   = (x < 0) ? longint'(-x) : x;
      t   = a >> 8;
      t2  = (t * t) >> 30;
      t3  = (t2 * t) >> 30;
      t4  = (t3 * t) >> 30;
      e   = Q30_ONE - t + t2 / 2 - t3 / 6 + t4 / 24;
      for (int i = 0; i < 8; i++) begin
         e = (e * e + (Q30_ONE >> 1)) >> 30;
      end
      den = Q30_ONE + e;
      if (x >= 0) begin
         s = udiv((64'd1 << 46) + den / 2, den);
      end else begin
         s = udiv((e << 16) + den / 2, den);
      end
      if (s > 64'd65535) begin
         return 16'hFFFF;
      end
      return s[15:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      for (int k = 0; k < SIG_DEPTH; k++) begin
         tbl[k] = sig_entry(k);
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// File: rtl/logistic_regression_sgd_step.sv
// one transaction at a time: req_ready is high only in idle, so a new request is taken
//    only after the last one has passed its result to the response register; a single
//    34x18 multiplier serves the dot product, the gradient and the weight updates
// the response register lets the next request start while a response waits
// reset (synchronous, active high): weights cleared, learning rate back to 6554
module logistic_regression_sgd_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [15:0] req_feature_0,
   input  logic signed [15:0] req_feature_1,
   input  logic signed [15:0] req_feature_2,
   input  logic signed [15:0] req_feature_3,
   input  logic [15:0]        req_target,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_prediction,
   output logic signed [16:0] rsp_error,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);
   import lrs_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DOT   = 4'd1;
   localparam logic [3:0] S_SUM   = 4'd2;
   localparam logic [3:0] S_LOOK  = 4'd3;
   localparam logic [3:0] S_ERR   = 4'd4;
   localparam logic [3:0] S_RATE  = 4'd5;
   localparam logic [3:0] S_AG    = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_UPD   = 4'd8;
   localparam logic [3:0] S_UPL   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam logic [15:0]             LR_RESET = 16'd6554;
   localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(NUM_FEATURES - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'((64'sd1 <<< (SAT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO   = -(SUM_W'(64'sd1 <<< (SAT_W - 1)));
   localparam logic signed [PROD_W-1:0] HALF16  = PROD_W'(64'sd1 <<< 15);
   localparam logic signed [PROD_W-1:0] HALF23  = PROD_W'(64'sd1 <<< 22);

   logic [3:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         upd_idx_ff, upd_idx_in;
   logic                     func_ff, func_in;
   logic signed [15:0]       x_ff [NUM_FEATURES];
   logic signed [15:0]       x_in [NUM_FEATURES];
   logic [15:0]              target_ff, target_in;
   logic signed [31:0]       w_ff [NUM_FEATURES];
   logic signed [31:0]       w_in [NUM_FEATURES];
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [15:0]              p_ff, p_in;
   logic signed [16:0]       err_ff, err_in;
   logic [14:0]              g_ff, g_in;
   logic signed [31:0]       scale_ff, scale_in;
   logic [15:0]              lr_ff, lr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_pred_ff, rsp_pred_in;
   logic signed [16:0]       rsp_err_ff, rsp_err_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic [15:0]               rom_data;
   logic [CNT_W-1:0]          rd_idx;
   logic signed [31:0]        w_rd;
   logic signed [SUM_W-1:0]   dot_sum;
   logic [SAT_W-1:0]          dot_sat;
   logic [SAT_W-1:0]          dot_off;
   logic [16:0]               one_minus_p;
   logic [32:0]               g_sum;
   logic signed [PROD_W-1:0]  scale_sum;
   logic signed [PROD_W-1:0]  scale_sh;
   logic signed [PROD_W-1:0]  delta_sum;
   logic signed [PROD_W-1:0]  delta_sh;
   logic signed [32:0]        w_sum;
   logic signed [31:0]        w_sat;

   lrs_sigmoid_rom u_rom (
      .clock   (clock),
      .rd_addr (idx_ff),
      .rd_data (rom_data)
   );

   // one weight read port shared between dot product and update
   assign rd_idx = (state_ff == S_DOT) ? cnt_ff : upd_idx_ff;
   assign w_rd   = w_ff[rd_idx];
   assign mul_p  = mul_a * mul_b;

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_error      = rsp_err_ff;

   // saturate the dot product and form the table index
   always_comb begin
      dot_sum = acc_ff + prod_ff[SUM_W-1:0];
      if (dot_sum > SAT_HI) begin
         dot_sat = SAT_HI[SAT_W-1:0];
      end else if (dot_sum < SAT_LO) begin
         dot_sat = SAT_LO[SAT_W-1:0];
      end else begin
         dot_sat = dot_sum[SAT_W-1:0];
      end
      dot_off = dot_sat ^ (SAT_W'(1) << (SAT_W - 1));
   end

   // rounding, half away from zero
   always_comb begin
      one_minus_p = 17'h10000 - {1'b0, rom_data};
      g_sum       = prod_ff[32:0] + 33'd32768;
      scale_sum   = prod_ff + HALF16 - PROD_W'(prod_ff[PROD_W-1]);
      scale_sh    = scale_sum >>> 16;
      delta_sum   = prod_ff + HALF23 - PROD_W'(prod_ff[PROD_W-1]);
      delta_sh    = delta_sum >>> 23;
      w_sum       = {w_rd[31], w_rd} + {delta_sh[31], delta_sh[31:0]};
      if (w_sum[32] != w_sum[31]) begin
         w_sat = w_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         w_sat = w_sum[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      upd_idx_in   = upd_idx_ff;
      func_in      = func_ff;
      x_in         = x_ff;
      target_in    = target_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      err_in       = err_ff;
      g_in         = g_ff;
      scale_in     = scale_ff;
      lr_in        = csr_write_enable ? csr_write_data : lr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_pred_in  = rsp_pred_ff;
      rsp_err_in   = rsp_err_ff;
      mul_a        = {{2{w_rd[31]}}, w_rd};
      mul_b        = {{2{x_ff[cnt_ff][15]}}, x_ff[cnt_ff]};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in[0]   = req_feature_0;
               x_in[1]   = req_feature_1;
               x_in[2]   = req_feature_2;
               x_in[3]   = req_feature_3;
               target_in = req_target;
               func_in   = req_func;
               cnt_in    = '0;
               acc_in    = '0;
               state_in  = S_DOT;
            end
         end
         S_DOT: begin
            prod_in = mul_p;
            // the product of the previous step joins the sum
            if (cnt_ff != '0) begin
               acc_in = dot_sum;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            idx_in   = dot_off[SAT_W-1 -: IDX_W];
            state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_ERR;
         end
         S_ERR: begin
            p_in    = rom_data;
            err_in  = {1'b0, target_ff} - {1'b0, rom_data};
            mul_a   = {18'd0, rom_data};
            mul_b   = {1'b0, one_minus_p};
            prod_in = mul_p;
            state_in = func_ff ? S_RATE : S_DONE;
         end
         S_RATE: begin
            g_in     = g_sum[30:16];
            mul_a    = {{17{err_ff[16]}}, err_ff};
            mul_b    = {2'b00, lr_ff};
            prod_in  = mul_p;
            state_in = S_AG;
         end
         S_AG: begin
            mul_a    = {prod_ff[32], prod_ff[32:0]};
            mul_b    = {3'b000, g_ff};
            prod_in  = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            scale_in = scale_sh[31:0];
            cnt_in   = '0;
            state_in = S_UPD;
         end
         S_UPD: begin
            mul_a   = {{2{scale_ff[31]}}, scale_ff};
            prod_in = mul_p;
            if (cnt_ff != '0) begin
               w_in[upd_idx_ff] = w_sat;
            end
            upd_idx_in = cnt_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_UPL;
            end
         end
         S_UPL: begin
            w_in[upd_idx_ff] = w_sat;
            state_in         = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pred_in  = p_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= LR_RESET;
         for (int i = 0; i < NUM_FEATURES; i++) begin
            w_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         w_ff         <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      upd_idx_ff  <= upd_idx_in;
      func_ff     <= func_in;
      x_ff        <= x_in;
      target_ff   <= target_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
      p_ff        <= p_in;
      err_ff      <= err_in;
      g_ff        <= g_in;
      scale_ff    <= scale_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_err_ff  <= rsp_err_in;
   end

endmodule

// File: rtl/lrs_sigmoid_rom.sv
module lrs_sigmoid_rom (
   input  logic                      clock,
   input  logic [lrs_pkg::IDX_W-1:0] rd_addr,
   output logic [15:0]               rd_data
);
   import lrs_pkg::*;

   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= SIG_TABLE[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/logistic_regression_sgd_step_test.sv
`timescale 1ns / 100ps

module logistic_regression_sgd_step_test;

   localparam int      FEATURES     = 4;
   localparam int      SIG_BINS     = 1024;
   localparam longint  SUM_LIMIT    = longint'(8) << 24;
   localparam longint  WEIGHT_MAX   = 64'sh7FFF_FFFF;
   localparam longint  WEIGHT_MIN   = -WEIGHT_MAX - 1;
   localparam longint unsigned Q30  = 64'd1 << 30;
   localparam logic [15:0] RATE_AT_RESET = 16'd6554;
   localparam int      SETTLE_CYCLES = 24;
   localparam int      DRAIN_CYCLES  = 40;
   localparam int      STALL_LIMIT   = 3000;
   localparam int      HOLD_CYCLES   = 300;

   typedef struct {
      logic [15:0]        prediction;
      logic signed [16:0] error;
   } sample_result_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic               req_func         = 1'b0;
   logic signed [15:0] req_feature_0    = '0;
   logic signed [15:0] req_feature_1    = '0;
   logic signed [15:0] req_feature_2    = '0;
   logic signed [15:0] req_feature_3    = '0;
   logic [15:0]        req_target       = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [15:0]        rsp_prediction;
   logic signed [16:0] rsp_error;
   logic               csr_write_enable = 1'b0;
   logic [15:0]        csr_write_data   = '0;

   // predicted state of the block
   logic [15:0]        sig_model [SIG_BINS];
   logic signed [31:0] weight_model [FEATURES];
   logic [15:0]        rate_model;

   sample_result_type  expected_results [$];
   int                 mismatch_count = 0;
   int                 idle_cycles = 0;
   int                 stall_left = 0;
   int                 rsp_hold_cycles = 0;
   bit                 no_gaps = 1'b0;

   logistic_regression_sgd_step dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_feature_0    (req_feature_0),
      .req_feature_1    (req_feature_1),
      .req_feature_2    (req_feature_2),
      .req_feature_3    (req_feature_3),
      .req_target       (req_target),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prediction   (rsp_prediction),
      .rsp_error        (rsp_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_half_away(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) begin
         return (v + half) >>> s;
      end
      return -((half - v) >>> s);
   endfunction

   // sigmoid at the centre of bin k: exp(-|x|) as a truncated series raised to the 256th
   function automatic logic [15:0] sigmoid_bin(input int k);
      longint          x;
      longint unsigned mag;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned t3;
      longint unsigned t4;
      longint unsigned e;
      longint unsigned den;
      longint unsigned q;
      x   = (longint'(2 * k + 1) * (longint'(8) << 30)) / SIG_BINS - (longint'(8) << 30);
      mag = (x < 0) ? -x : x;
      t   = mag >> 8;
      t2  = (t * t) >> 30;
      t3  = (t2 * t) >> 30;
      t4  = (t3 * t) >> 30;
      e   = Q30 - t + t2 / 2 - t3 / 6 + t4 / 24;
      repeat (8) begin
         e = (e * e + (Q30 >> 1)) >> 30;
      end
      den = Q30 + e;
      if (x >= 0) begin
         q = ((64'd1 << 46) + den / 2) / den;
      end else begin
         q = ((e << 16) + den / 2) / den;
      end
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   // forward pass, then the weight step when training
   function automatic void predict_sample(input logic fn,
                                          input logic signed [15:0] f0, f1, f2, f3,
                                          input logic [15:0] tgt);
      longint            feat [FEATURES];
      longint            acc;
      longint            bin;
      longint            p;
      longint            err;
      longint            g;
      longint            scaled_rate;
      longint            scale;
      longint            delta;
      longint            w;
      sample_result_type want;
      feat[0] = longint'(f0);
      feat[1] = longint'(f1);
      feat[2] = longint'(f2);
      feat[3] = longint'(f3);
      acc = 0;
      for (int i = 0; i < FEATURES; i++) begin
         acc += longint'(weight_model[i]) * feat[i];
      end
      if (acc < -SUM_LIMIT) begin
         acc = -SUM_LIMIT;
      end
      if (acc > SUM_LIMIT - 1) begin
         acc = SUM_LIMIT - 1;
      end
      bin = ((acc + SUM_LIMIT) * SIG_BINS) >>> 28;
      if (bin > SIG_BINS - 1) begin
         bin = SIG_BINS - 1;
      end
      p   = longint'(sig_model[bin[9:0]]);
      err = longint'(tgt) - p;
      if (fn) begin
         g           = round_half_away(p * (65536 - p), 16);
         scaled_rate = err * longint'(rate_model);
         scale       = round_half_away(scaled_rate * g, 16);
         for (int i = 0; i < FEATURES; i++) begin
            delta = round_half_away(2 * scale * feat[i], 24);
            w     = longint'(weight_model[i]) + delta;
            if (w > WEIGHT_MAX) begin
               w = WEIGHT_MAX;
            end
            if (w < WEIGHT_MIN) begin
               w = WEIGHT_MIN;
            end
            weight_model[i] = w[31:0];
         end
      end
      want.prediction = p[15:0];
      want.error      = err[16:0];
      expected_results.insert(expected_results.size(), want);
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [15:0] pick_feature();
      int v;
      case ($urandom_range(0, 9))
         0: begin
            return 16'sh8000;
         end
         1: begin
            return 16'sh7FFF;
         end
         2, 3, 4: begin
            // small magnitudes keep the dot product off the table ends
            v = $urandom_range(0, 1023);
            return 16'(v - 512);
         end
         default: begin
            return 16'($urandom());
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_target();
      case ($urandom_range(0, 7))
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'hFFFF;
         end
         default: begin
            return 16'($urandom());
         end
      endcase
   endfunction

   initial begin
      for (int k = 0; k < SIG_BINS; k++) begin
         sig_model[k] = sigmoid_bin(k);
      end
      for (int i = 0; i < FEATURES; i++) begin
         weight_model[i] = '0;
      end
      rate_model = RATE_AT_RESET;
   end

   // model update on each register write and each accepted sample
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            rate_model = csr_write_data;
         end
         if (req_valid && req_ready) begin
            predict_sample(req_func, req_feature_0, req_feature_1, req_feature_2,
                           req_feature_3, req_target);
         end
      end
   end

   // response side: compare, then decide on ready for the next cycle
   always @(posedge clock) begin
      sample_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response with no sample outstanding, prediction %0d error %0d",
                     $time, rsp_prediction, rsp_error);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_prediction !== want.prediction) begin
               $display("%0t: prediction expected %0d actual %0d",
                        $time, want.prediction, rsp_prediction);
               mismatch_count++;
            end
            if (rsp_error !== want.error) begin
               $display("%0t: error expected %0d actual %0d", $time, want.error, rsp_error);
               mismatch_count++;
            end
         end
      end
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!no_gaps && $urandom_range(0, 2) == 0) begin
            stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // entered and left in the time step of a clock edge; valid stays up when there is no gap
   task automatic send_sample(input logic fn,
                              input logic signed [15:0] f0, f1, f2, f3,
                              input logic [15:0] tgt);
      int gap;
      gap = no_gaps ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= fn;
      req_feature_0 <= f0;
      req_feature_1 <= f1;
      req_feature_2 <= f2;
      req_feature_3 <= f3;
      req_target    <= tgt;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic send_random_sample();
      send_sample(1'($urandom_range(0, 1)), pick_feature(), pick_feature(), pick_feature(),
                  pick_feature(), pick_target());
   endtask

   // rate changes only once every response is back and any weight update has finished
   task automatic write_rate(input logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_sample(1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
      send_sample(1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF);
      // training step with the rate left at its reset value
      send_sample(1'b1, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'hFFFF);
   endtask

   task automatic test_field_extremes();
      send_sample(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
      send_sample(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000);
      send_sample(1'b1, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'hFFFF);
      send_sample(1'b1, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000, 16'h0000);
      send_sample(1'b1, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'h8000);
      send_sample(1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'hFFFF);
      send_sample(1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000);
      send_sample(1'b0, 16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0000, 16'h0001);
   endtask

   // big weights drive the dot product past both table ends
   task automatic test_sum_saturation();
      write_rate(16'hFFFF);
      send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
      send_sample(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
      send_sample(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000);
      send_sample(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000);
      send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000);
      send_sample(1'b0, 16'sh7FFF, 16'sh8000, 16'sh0100, 16'shFF00, 16'h8000);
   endtask

   task automatic test_zero_rate();
      write_rate(16'h0000);
      send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000);
      send_sample(1'b1, 16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh8000, 16'hFFFF);
      send_sample(1'b1, 16'sh0040, 16'shFFC0, 16'sh0010, 16'sh0000, 16'h4000);
      send_sample(1'b0, 16'sh0040, 16'shFFC0, 16'sh0010, 16'sh0000, 16'h4000);
   endtask

   // receiver stops for a long stretch while samples keep coming
   task automatic test_back_pressure();
      write_rate(16'($urandom_range(1, 65535)));
      rsp_hold_cycles = HOLD_CYCLES;
      no_gaps = 1'b1;
      repeat (16) send_random_sample();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_training();
      logic [15:0] rate_choice;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               rate_choice = 16'hFFFF;
            end
            1: begin
               rate_choice = 16'd1;
            end
            5: begin
               rate_choice = RATE_AT_RESET;
            end
            default: begin
               rate_choice = 16'($urandom_range(0, 65535));
            end
         endcase
         write_rate(rate_choice);
         for (int chunk = 0; chunk < 3; chunk++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (50) send_random_sample();
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_field_extremes();
      test_sum_saturation();
      test_zero_rate();
      test_back_pressure();
      test_random_training();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
